// File: rtl/fbpsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fbpsr_pkg;

    // Field widths
    localparam int PRESS_W = 15;
    localparam int FLOW_W  = 16;
    localparam int TIME_W  = 48;
    localparam int IVAL_W  = 16;
    localparam int STAT_W  = 2;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 16;
    localparam int IV_MS_W = 26;
    localparam int PROD_W  = 48;
    localparam int DEN_W   = 32;
    localparam int QUO_W   = 15;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_DEFAULT_PRESS = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_MIN_PRESS     = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_MAX_PRESS     = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_RAMP_STEP     = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_INTERVAL_S    = 3'd4;
    localparam logic [CFG_A_W-1:0] CFG_STATIC_HEAD   = 3'd5;
    localparam logic [CFG_A_W-1:0] CFG_RATE_HEAD     = 3'd6;
    localparam logic [CFG_A_W-1:0] CFG_DESIGN_FLOW   = 3'd7;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_COMPUTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_CFG   = 2'd1;
    localparam logic [STAT_W-1:0] ST_WAIT     = 2'd2;
    localparam logic [STAT_W-1:0] ST_RECORDED = 2'd3;

    // Constants
    localparam logic [PRESS_W-1:0] PRESS_CAP         = 15'd20000;
    localparam logic [PRESS_W-1:0] STEP_FALLBACK     = 15'd20;
    localparam logic [IVAL_W-1:0]  INTERVAL_FALLBACK = 16'd60;
    localparam logic [IVAL_W-1:0]  INTERVAL_MIN      = 16'd10;
    localparam logic [IV_MS_W-1:0] MS_PER_S          = 26'd1000;

    // Microcode
    localparam int PC_W = 4;

    localparam logic [3:0] OP_IDLE  = 4'd0;
    localparam logic [3:0] OP_DIFF  = 4'd1;
    localparam logic [3:0] OP_CHECK = 4'd2;
    localparam logic [3:0] OP_MUL1  = 4'd3;
    localparam logic [3:0] OP_MUL2  = 4'd4;
    localparam logic [3:0] OP_ADDH  = 4'd5;
    localparam logic [3:0] OP_DINIT = 4'd6;
    localparam logic [3:0] OP_DSTEP = 4'd7;
    localparam logic [3:0] OP_SUM   = 4'd8;
    localparam logic [3:0] OP_CLAMP = 4'd9;
    localparam logic [3:0] OP_RAMP  = 4'd10;
    localparam logic [3:0] OP_EMIT  = 4'd11;

    localparam logic [2:0] C_NEXT     = 3'd0;
    localparam logic [2:0] C_WAIT_IN  = 3'd1;
    localparam logic [2:0] C_SKIP     = 3'd2;
    localparam logic [2:0] C_OVF      = 3'd3;
    localparam logic [2:0] C_LOOP     = 3'd4;
    localparam logic [2:0] C_WAIT_OUT = 3'd5;

    localparam logic [PC_W-1:0] PC_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] PC_DSTEP = 4'd7;
    localparam logic [PC_W-1:0] PC_SUM   = 4'd8;
    localparam logic [PC_W-1:0] PC_EMIT  = 4'd11;

    typedef struct packed {
        logic [3:0]      op;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } t_uop;

    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        unique case (pc)
            4'd0:    u = '{op: OP_IDLE,  cond: C_WAIT_IN,  target: PC_IDLE};
            4'd1:    u = '{op: OP_DIFF,  cond: C_NEXT,     target: PC_IDLE};
            4'd2:    u = '{op: OP_CHECK, cond: C_SKIP,     target: PC_EMIT};
            4'd3:    u = '{op: OP_MUL1,  cond: C_NEXT,     target: PC_IDLE};
            4'd4:    u = '{op: OP_MUL2,  cond: C_NEXT,     target: PC_IDLE};
            4'd5:    u = '{op: OP_ADDH,  cond: C_NEXT,     target: PC_IDLE};
            4'd6:    u = '{op: OP_DINIT, cond: C_OVF,      target: PC_SUM};
            4'd7:    u = '{op: OP_DSTEP, cond: C_LOOP,     target: PC_DSTEP};
            4'd8:    u = '{op: OP_SUM,   cond: C_NEXT,     target: PC_IDLE};
            4'd9:    u = '{op: OP_CLAMP, cond: C_NEXT,     target: PC_IDLE};
            4'd10:   u = '{op: OP_RAMP,  cond: C_NEXT,     target: PC_IDLE};
            4'd11:   u = '{op: OP_EMIT,  cond: C_WAIT_OUT, target: PC_IDLE};
            default: u = '{op: OP_IDLE,  cond: C_WAIT_IN,  target: PC_IDLE};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// File: rtl/flow_based_pressure_setpoint_ramp.sv
// A computed evaluation steps through DIFF, CHECK, MUL1, MUL2, ADDH, DINIT, the 15-step
// divider, SUM, CLAMP, RAMP and EMIT; a saturating quadratic term skips the divider, and
// record/skipped beats go from CHECK to EMIT. No new beat is taken before the result is registered.
// Reset (i_rst_n low, synchronous): config back to defaults, no previous target,
// no write time recorded, sequencer idle, output empty.
`timescale 1ns / 1ps
`default_nettype none

module flow_based_pressure_setpoint_ramp
    import fbpsr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_A_W-1:0]    i_cfg_addr,
    input  wire logic [CFG_D_W-1:0]    i_cfg_wdata,
    // input stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [79:0]           i_s_axis_tdata,  // current_flow, avg_flow, now_ms
    input  wire logic                  i_s_axis_tuser,  // mode
    // result stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [31:0]                o_m_axis_tdata,  // target_press, write_press, pad
    output logic [STAT_W-1:0]          o_m_axis_tuser   // status
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PRESS_W-1:0] r_default_press, r_min_press, r_max_press, r_ramp_step;
    logic [PRESS_W-1:0] r_static_head, r_rate_head;
    logic [IVAL_W-1:0]  r_interval_s;
    logic [FLOW_W-1:0]  r_design_flow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_press <= 15'd3000;
            r_min_press     <= 15'd2000;
            r_max_press     <= 15'd5000;
            r_ramp_step     <= 15'd20;
            r_interval_s    <= 16'd60;
            r_static_head   <= 15'd3400;
            r_rate_head     <= 15'd400;
            r_design_flow   <= 16'd4500;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DEFAULT_PRESS: r_default_press <= i_cfg_wdata[PRESS_W-1:0];
                CFG_MIN_PRESS:     r_min_press     <= i_cfg_wdata[PRESS_W-1:0];
                CFG_MAX_PRESS:     r_max_press     <= i_cfg_wdata[PRESS_W-1:0];
                CFG_RAMP_STEP:     r_ramp_step     <= i_cfg_wdata[PRESS_W-1:0];
                CFG_INTERVAL_S:    r_interval_s    <= i_cfg_wdata;
                CFG_STATIC_HEAD:   r_static_head   <= i_cfg_wdata[PRESS_W-1:0];
                CFG_RATE_HEAD:     r_rate_head     <= i_cfg_wdata[PRESS_W-1:0];
                CFG_DESIGN_FLOW:   r_design_flow   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: program counter plus control word from the ROM
    // ------------------------------------------------------------------
    logic [PC_W-1:0] r_pc, n_pc;
    t_uop            w_uop;
    logic [3:0]      r_cnt;    // divide steps left

    logic w_in_acc, w_out_free, w_skip, w_ovf, w_emit;

    assign w_uop           = uop_rom(r_pc);
    assign o_s_axis_tready = (r_pc == PC_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !o_m_axis_tvalid || i_m_axis_tready;
    assign w_emit          = (w_uop.op == OP_EMIT) && w_out_free;

    always_comb begin
        unique case (w_uop.cond)
            C_NEXT:     n_pc = r_pc + 1'b1;
            C_WAIT_IN:  n_pc = w_in_acc ? r_pc + 1'b1 : r_pc;
            C_SKIP:     n_pc = w_skip ? w_uop.target : r_pc + 1'b1;
            C_OVF:      n_pc = w_ovf ? w_uop.target : r_pc + 1'b1;
            C_LOOP:     n_pc = (r_cnt != '0) ? w_uop.target : r_pc + 1'b1;
            C_WAIT_OUT: n_pc = w_out_free ? w_uop.target : r_pc;
            default:    n_pc = PC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    // item registers
    logic                r_mode;
    logic [FLOW_W-1:0]   r_flow;
    logic [TIME_W-1:0]   r_now;
    // state
    logic [PRESS_W-1:0]  r_prev_tgt;
    logic [TIME_W-1:0]   r_last_wr;
    // work registers
    logic [TIME_W:0]     r_diff;   // signed now - last
    logic [IV_MS_W-1:0]  r_ivms;
    logic [PROD_W-1:0]   r_prod;   // product, then numerator, then remainder
    logic [DEN_W-1:0]    r_den;
    logic [PROD_W-1:0]   r_dsh;    // shifted divisor
    logic [QUO_W-1:0]    r_quo;
    logic                r_ovf;
    logic [PRESS_W-1:0]  r_t;
    logic [STAT_W-1:0]   r_status;
    logic [PRESS_W-1:0]  r_tgt, r_wr;

    // interval in ms, short intervals fall back to a minute
    logic [IVAL_W-1:0]   w_iv;
    logic [IV_MS_W-1:0]  w_ivms;
    assign w_iv   = (r_interval_s < INTERVAL_MIN) ? INTERVAL_FALLBACK : r_interval_s;
    assign w_ivms = IV_MS_W'(w_iv) * MS_PER_S;

    // skip decision
    logic w_cfg_bad, w_pending;
    logic [STAT_W-1:0] w_status;
    assign w_cfg_bad = (r_default_press == '0) || (r_min_press == '0) ||
                       (r_max_press == '0) || (r_design_flow == '0);
    assign w_pending = (r_last_wr != '0) &&
                       ($signed(r_diff) < $signed({23'd0, r_ivms}));
    always_comb begin
        priority if (r_mode)  w_status = ST_RECORDED;
        else if (w_cfg_bad)   w_status = ST_NO_CFG;
        else if (w_pending)   w_status = ST_WAIT;
        else                  w_status = ST_COMPUTED;
    end
    assign w_skip = (w_status != ST_COMPUTED);

    // multiplies, each registered before the next
    logic [30:0] w_mul1;
    logic [46:0] w_mul2;
    logic [31:0] w_den;
    assign w_mul1 = r_rate_head * r_flow;
    assign w_mul2 = r_prod[30:0] * r_flow;
    assign w_den  = r_design_flow * r_design_flow;

    // quotient would not fit 15 bits: term saturates
    logic [PROD_W-1:0] w_dlim;
    assign w_dlim = {1'b0, r_den, 15'd0};
    assign w_ovf  = (r_prod >= w_dlim);

    // restoring divide step
    logic w_ge;
    assign w_ge = (r_prod >= r_dsh);

    // static head plus term, saturated
    logic [PRESS_W:0] w_sum;
    assign w_sum = {1'b0, r_static_head} + {1'b0, r_quo};

    // zero target falls back, then min before max
    logic [PRESS_W-1:0] w_t0, w_clamp;
    assign w_t0 = (r_t == '0) ? r_default_press : r_t;
    always_comb begin
        priority if (w_t0 < r_min_press) w_clamp = r_min_press;
        else if (w_t0 > r_max_press)     w_clamp = r_max_press;
        else                             w_clamp = w_t0;
    end

    // ramp limiter
    logic [PRESS_W-1:0] w_step, w_base, w_down, w_ramp;
    logic [PRESS_W:0]   w_up;
    assign w_step = (r_ramp_step == '0) ? STEP_FALLBACK : r_ramp_step;
    assign w_base = (r_prev_tgt == '0) ? r_default_press : r_prev_tgt;
    assign w_up   = {1'b0, w_base} + {1'b0, w_step};
    assign w_down = w_base - r_tgt;
    always_comb begin
        priority if (r_tgt == w_base)    w_ramp = w_base;
        else if (r_tgt > w_base)         w_ramp = (w_up > {1'b0, r_tgt}) ? r_tgt
                                                                         : w_up[PRESS_W-1:0];
        else if (w_down > w_step)        w_ramp = w_base - w_step;
        else                             w_ramp = r_tgt;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_tgt <= '0;
            r_last_wr  <= '0;
        end else begin
            if ((w_uop.op == OP_CHECK) && r_mode) begin
                r_last_wr <= r_now;
            end
            if (w_uop.op == OP_RAMP) begin
                r_prev_tgt <= r_tgt;
            end
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        unique case (w_uop.op)
            OP_IDLE: begin
                if (w_in_acc) begin
                    r_mode <= i_s_axis_tuser;
                    r_flow <= (i_s_axis_tdata[31:16] != '0) ? i_s_axis_tdata[31:16]
                                                            : i_s_axis_tdata[15:0];
                    r_now  <= i_s_axis_tdata[79:32];
                end
            end
            OP_DIFF: begin
                r_diff <= {1'b0, r_now} - {1'b0, r_last_wr};
                r_ivms <= w_ivms;
            end
            OP_CHECK: begin
                r_status <= w_status;
                r_tgt    <= '0;
                r_wr     <= '0;
            end
            OP_MUL1: begin
                r_prod <= PROD_W'(w_mul1);
                r_den  <= w_den;
            end
            OP_MUL2: begin
                r_prod <= PROD_W'(w_mul2);
            end
            OP_ADDH: begin
                // round half up
                r_prod <= r_prod + PROD_W'(r_den >> 1);
            end
            OP_DINIT: begin
                r_ovf <= w_ovf;
                r_dsh <= {2'd0, r_den, 14'd0};
                r_quo <= '0;
                r_cnt <= 4'd14;
            end
            OP_DSTEP: begin
                if (w_ge) begin
                    r_prod <= r_prod - r_dsh;
                end
                r_quo <= {r_quo[QUO_W-2:0], w_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            OP_SUM: begin
                r_t <= (r_ovf || (w_sum > {1'b0, PRESS_CAP})) ? PRESS_CAP
                                                              : w_sum[PRESS_W-1:0];
            end
            OP_CLAMP: begin
                r_tgt <= w_clamp;
            end
            OP_RAMP: begin
                r_wr <= w_ramp;
            end
            OP_EMIT: ;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [STAT_W-1:0]  r_o_status;
    logic [PRESS_W-1:0] r_o_tgt, r_o_wr;
    logic               r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_emit) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_status <= r_status;
            r_o_tgt    <= r_tgt;
            r_o_wr     <= r_wr;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tuser  = r_o_status;
    assign o_m_axis_tdata  = {2'd0, r_o_wr, r_o_tgt};

endmodule

`default_nettype wire

// File: rtl/fbpsr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fbpsr_checker
    import fbpsr_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_s_axis_tvalid,
    input wire logic               o_s_axis_tready,
    input wire logic               o_m_axis_tvalid,
    input wire logic               i_m_axis_tready,
    input wire logic [31:0]        o_m_axis_tdata,
    input wire logic [STAT_W-1:0]  o_m_axis_tuser
);

    // output empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat valid after reset");

    // one item at a time: busy the cycle after an accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while an item is in work");

    // non-computed results carry zero pressures
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != ST_COMPUTED)) |-> (o_m_axis_tdata == '0))
        else $error("pressure fields set on a skipped or record result");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result beat changed");

endmodule

bind flow_based_pressure_setpoint_ramp fbpsr_checker u_fbpsr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import fbpsr_pkg::*;

    localparam logic MODE_EVAL   = 1'b0;
    localparam logic MODE_RECORD = 1'b1;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned BEATS_PER_PHASE = 194;
    localparam int unsigned SETTLE_CYCLES   = 30;
    localparam int unsigned PRINT_LIMIT     = 20;

    typedef struct packed {
        logic              mode;
        logic [FLOW_W-1:0] cur_flow;
        logic [FLOW_W-1:0] avg_flow;
        logic [TIME_W-1:0] now_ms;
    } t_flow_beat;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [PRESS_W-1:0] target;
        logic [PRESS_W-1:0] write;
    } t_setpoint;

    typedef enum logic [1:0] {GAPS_NONE, GAPS_SENDER, GAPS_RECEIVER, GAPS_BOTH} t_gap_mode;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // block connections
    logic                cfg_we    = 1'b0;
    logic [CFG_A_W-1:0]  cfg_addr  = '0;
    logic [CFG_D_W-1:0]  cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    t_flow_beat          s_beat    = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [31:0]         m_tdata;
    logic [STAT_W-1:0]   m_tuser;

    flow_based_pressure_setpoint_ramp DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        // current_flow [15:0], avg_flow [31:16], now_ms [79:32]
        .i_s_axis_tdata  ({s_beat.now_ms, s_beat.avg_flow, s_beat.cur_flow}),
        .i_s_axis_tuser  (s_beat.mode),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        // target_press [14:0], write_press [29:15], pad [31:30]
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    // beats waiting for the driver, results waiting for the monitor
    t_flow_beat  beats_to_send [$];
    t_setpoint   results_due [$];
    t_gap_mode   gap_mode = GAPS_NONE;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // shadow of the block: registers, last target, time of last write
    int unsigned        reg_val [8];
    int unsigned        prev_target;
    logic [TIME_W-1:0]  last_write;

    // stimulus-side view of the write time, used to place beats around the interval
    logic [TIME_W-1:0]  gen_last;
    logic [TIME_W-1:0]  gen_now;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // ---------------------------------------------------------------------
    // Setpoint predictor
    // ---------------------------------------------------------------------

    // static head plus rounded quadratic term, saturated, defaulted, clamped
    function automatic int unsigned flow_target(input logic [FLOW_W-1:0] flow);
        logic [63:0] den, num, quo;
        int unsigned t;
        den = 64'(reg_val[CFG_DESIGN_FLOW]) * 64'(reg_val[CFG_DESIGN_FLOW]);
        num = 64'(reg_val[CFG_RATE_HEAD]) * 64'(flow) * 64'(flow);
        quo = (num + den / 2) / den;
        if (quo > 64'(PRESS_CAP))
            quo = 64'(PRESS_CAP) + 64'd1;
        t = reg_val[CFG_STATIC_HEAD] + quo[31:0];
        if (t > PRESS_CAP)
            t = PRESS_CAP;
        if (t == 0)
            t = reg_val[CFG_DEFAULT_PRESS];
        // lower bound wins when the clamp is inverted
        if (t < reg_val[CFG_MIN_PRESS])
            t = reg_val[CFG_MIN_PRESS];
        else if (t > reg_val[CFG_MAX_PRESS])
            t = reg_val[CFG_MAX_PRESS];
        return t;
    endfunction

    // one ramp step from the last target toward the new one, no overshoot
    function automatic int unsigned ramped_write(input int unsigned tgt);
        int unsigned step, w;
        step = (reg_val[CFG_RAMP_STEP] != 0) ? reg_val[CFG_RAMP_STEP] : int'(STEP_FALLBACK);
        w = (prev_target != 0) ? prev_target : reg_val[CFG_DEFAULT_PRESS];
        if (tgt > w) begin
            w = w + step;
            if (w > tgt)
                w = tgt;
        end else if (tgt < w) begin
            w = (w - tgt > step) ? w - step : tgt;
        end
        return w;
    endfunction

    function automatic int unsigned interval_ms();
        int unsigned iv;
        iv = (reg_val[CFG_INTERVAL_S] < INTERVAL_MIN) ? int'(INTERVAL_FALLBACK)
                                                      : reg_val[CFG_INTERVAL_S];
        return iv * int'(MS_PER_S);
    endfunction

    function automatic void predict_setpoint(input t_flow_beat b);
        t_setpoint   r;
        longint      gap;
        int unsigned tgt;
        int unsigned wr;
        r = '0;
        gap = $signed({16'b0, b.now_ms}) - $signed({16'b0, last_write});
        if (b.mode == MODE_RECORD) begin
            last_write = b.now_ms;
            r.status = ST_RECORDED;
        end else if (reg_val[CFG_DEFAULT_PRESS] == 0 || reg_val[CFG_MIN_PRESS] == 0 ||
                     reg_val[CFG_MAX_PRESS] == 0 || reg_val[CFG_DESIGN_FLOW] == 0) begin
            r.status = ST_NO_CFG;
        end else if (last_write != 0 && gap < longint'(interval_ms())) begin
            // also catches time running backwards
            r.status = ST_WAIT;
        end else begin
            tgt = flow_target((b.avg_flow != 0) ? b.avg_flow : b.cur_flow);
            wr  = ramped_write(tgt);
            r.status = ST_COMPUTED;
            r.target = tgt[PRESS_W-1:0];
            r.write  = wr[PRESS_W-1:0];
            prev_target = tgt;
        end
        results_due.push_back(r);
    endfunction

    // ---------------------------------------------------------------------
    // Driver: presents queued beats, predicts on each accepted beat
    // ---------------------------------------------------------------------

    function automatic bit sender_gap();
        case (gap_mode)
            GAPS_SENDER: return $urandom_range(99) < 80;
            GAPS_BOTH:   return $urandom_range(99) < 13;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (gap_mode)
            GAPS_RECEIVER: return $urandom_range(99) < 80;
            GAPS_BOTH:     return $urandom_range(99) < 13;
            default:       return 1'b0;
        endcase
    endfunction

    logic beat_taken;

    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            beat_taken = s_tvalid && s_tready;
            if (beat_taken)
                predict_setpoint(s_beat);
            if (!s_tvalid || beat_taken) begin
                if (beats_to_send.size() != 0 && !sender_gap()) begin
                    s_beat   <= beats_to_send.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: random backpressure, field-by-field compare
    // ---------------------------------------------------------------------

    t_setpoint due;

    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !receiver_stall();
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected result, status", m_tuser, 0);
                end else begin
                    due = results_due.pop_front();
                    if (m_tuser != due.status)
                        report_mismatch("status", m_tuser, due.status);
                    if (m_tdata[PRESS_W-1:0] != due.target)
                        report_mismatch("target_press", m_tdata[PRESS_W-1:0], due.target);
                    if (m_tdata[2*PRESS_W-1:PRESS_W] != due.write)
                        report_mismatch("write_press", m_tdata[2*PRESS_W-1:PRESS_W],
                                        due.write);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[flow_based_pressure_setpoint_ramp] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------

    task automatic drain();
        while (beats_to_send.size() != 0 || s_tvalid || results_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val[CFG_D_W-1:0];
        reg_val[idx] = val;
    endtask

    // waits for the block to go idle, then rewrites every register
    task automatic set_cfg(input int unsigned dflt, input int unsigned lo,
                           input int unsigned hi, input int unsigned step,
                           input int unsigned ival, input int unsigned shead,
                           input int unsigned rhead, input int unsigned dflow);
        drain();
        write_reg(CFG_DEFAULT_PRESS, dflt);
        write_reg(CFG_MIN_PRESS, lo);
        write_reg(CFG_MAX_PRESS, hi);
        write_reg(CFG_RAMP_STEP, step);
        write_reg(CFG_INTERVAL_S, ival);
        write_reg(CFG_STATIC_HEAD, shead);
        write_reg(CFG_RATE_HEAD, rhead);
        write_reg(CFG_DESIGN_FLOW, dflow);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic push_eval(input logic [FLOW_W-1:0] cur, input logic [FLOW_W-1:0] avg,
                             input logic [TIME_W-1:0] now);
        beats_to_send.push_back('{MODE_EVAL, cur, avg, now});
    endtask

    task automatic push_record(input logic [TIME_W-1:0] now);
        beats_to_send.push_back('{MODE_RECORD, FLOW_W'($urandom_range(65535)),
                                  FLOW_W'($urandom_range(65535)), now});
        gen_last = now;
        gen_now  = now;
    endtask

    // typical value most of the time, sometimes zero, one or the extreme
    function automatic int unsigned pick_reg(input int unsigned extreme,
                                             input int unsigned lo, input int unsigned hi);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 3)  return 0;
        if (r < 12) return extreme;
        if (r < 16) return 1;
        return $urandom_range(hi, lo);
    endfunction

    task automatic random_cfg();
        int unsigned ival;
        ival = ($urandom_range(99) < 20) ? $urandom_range(9) : pick_reg(65535, 10, 120);
        set_cfg(pick_reg(20000, 1000, 8000), pick_reg(20000, 500, 4000),
                pick_reg(20000, 3000, 12000), pick_reg(20000, 0, 300), ival,
                pick_reg(20000, 0, 6000), pick_reg(20000, 0, 5000),
                pick_reg(65535, 500, 10000));
    endtask

    function automatic logic [FLOW_W-1:0] pick_flow();
        int unsigned d;
        d = reg_val[CFG_DESIGN_FLOW];
        case ($urandom_range(3))
            0:       return FLOW_W'($urandom_range(65535));
            1:       return FLOW_W'($urandom_range((d * 2 > 65535 || d == 0) ? 65535 : d * 2));
            2:       return ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
            default: return FLOW_W'((d > 65535 - 50) ? d : d + $urandom_range(50));
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] any_time();
        logic [63:0] r64;
        r64 = {$urandom, $urandom};
        return r64[TIME_W-1:0];
    endfunction

    // mostly record/evaluate cycles that clear the interval, plus early and wild times
    task automatic random_beat();
        int unsigned r;
        logic [FLOW_W-1:0] avg;
        logic [TIME_W-1:0] now;
        r   = $urandom_range(99);
        avg = ($urandom_range(99) < 30) ? 16'd0 : pick_flow();
        if (r < 10) begin
            push_record(gen_now + $urandom_range(1000));
        end else if (r < 15) begin
            push_record(($urandom_range(1)) ? any_time() : 48'd0);
        end else if (r < 70) begin
            now = gen_last + interval_ms();
            if ($urandom_range(3) != 0)
                now = now + $urandom_range(5000);
            gen_now = now;
            push_eval(pick_flow(), avg, now);
        end else if (r < 85) begin
            push_eval(pick_flow(), avg, gen_last + $urandom_range(interval_ms() - 1));
        end else begin
            push_eval(pick_flow(), avg, any_time());
        end
    endtask

    initial begin
        reg_val[CFG_DEFAULT_PRESS] = 3000;
        reg_val[CFG_MIN_PRESS]     = 2000;
        reg_val[CFG_MAX_PRESS]     = 5000;
        reg_val[CFG_RAMP_STEP]     = 20;
        reg_val[CFG_INTERVAL_S]    = 60;
        reg_val[CFG_STATIC_HEAD]   = 3400;
        reg_val[CFG_RATE_HEAD]     = 400;
        reg_val[CFG_DESIGN_FLOW]   = 4500;
        prev_target = 0;
        last_write  = '0;
        gen_last    = '0;
        gen_now     = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: first ramp from default, avg vs current flow, saturation,
        // interval edge, backwards time, write at the top of the time range and at zero
        push_eval(16'd4500, 16'd0, 48'd0);
        push_eval(16'd0, 16'd4500, 48'd5);
        push_eval(16'hFFFF, 16'hFFFF, 48'd10);
        push_record(48'd1000);
        push_eval(16'd3000, 16'd0, 48'd60999);
        push_eval(16'd3000, 16'd0, 48'd61000);
        push_eval(16'd3000, 16'd0, 48'd500);
        push_record(48'hFFFF_FFFF_FFFF);
        push_eval(16'd3000, 16'd0, 48'd0);
        push_record(48'd0);
        push_eval(16'd2250, 16'd0, 48'd20);

        // zero target -> default, inverted clamp, zero step and short interval fall back
        gap_mode = GAPS_BOTH;
        set_cfg(3000, 6000, 4000, 0, 5, 0, 0, 4500);
        push_eval(16'd0, 16'd0, 48'd30);
        push_record(48'd100);
        push_eval(16'd0, 16'd0, 48'd60099);
        push_eval(16'd0, 16'd0, 48'd60100);
        push_record(48'd0);

        // register extremes
        set_cfg(3000, 1, 20000, 20000, 10, 20000, 20000, 1);
        push_eval(16'd1, 16'd0, 48'd40);
        set_cfg(3000, 1, 20000, 1, 65535, 0, 1, 65535);
        push_eval(16'd0, 16'd0, 48'd60);
        push_eval(16'hFFFF, 16'd0, 48'd70);

        // incomplete configuration, one missing register at a time
        set_cfg(0, 2000, 5000, 20, 60, 3400, 400, 4500);
        push_eval(16'd4500, 16'd0, 48'd80);
        push_record(48'd0);
        set_cfg(3000, 2000, 5000, 20, 60, 3400, 400, 0);
        push_eval(16'd4500, 16'd0, 48'd90);
        set_cfg(3000, 0, 5000, 20, 60, 3400, 400, 4500);
        push_eval(16'd4500, 16'd0, 48'd95);
        set_cfg(3000, 2000, 0, 20, 60, 3400, 400, 4500);
        push_eval(16'd4500, 16'd0, 48'd99);

        // longest interval, both sides of its edge
        set_cfg(3000, 2000, 5000, 20, 65535, 3400, 400, 4500);
        push_record(48'd7);
        push_eval(16'd4500, 16'd0, 48'd65535006);
        push_eval(16'd4500, 16'd0, 48'd65535007);
        push_record(48'd0);

        // random settings, cycling through the gap patterns
        for (int p = 0; p < 8; p++) begin
            random_cfg();
            gap_mode = t_gap_mode'(p % 4);
            repeat (BEATS_PER_PHASE) random_beat();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (results_due.size() != 0)
            report_mismatch("results never delivered", 0, results_due.size());
        if (mismatch_count == 0) begin
            $display("[flow_based_pressure_setpoint_ramp] OK");
        end else begin
            $display("[flow_based_pressure_setpoint_ramp] ERROR");
        end
        $finish;
    end

endmodule
